/* hw/rtl/rpa_pkg.sv */
// Shared types, constants and codes of the reference-counted page allocator.
`timescale 1ns / 1ps
package rpa_pkg;

  // Sizing
  localparam int unsigned NUM_PAGES  = 32768;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned COUNT_BITS = 8;
  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES);
  localparam int unsigned DEPTH_W    = PAGE_W + 1;
  localparam int unsigned OFF_W      = 28;
  localparam int unsigned IDX_W      = OFF_W - PAGE_SHIFT;
  localparam int unsigned POFF_W     = 27;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned REQ_W      = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FREE_ZERO = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_MEM    = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [OFF_W-1:0] address_offset;
  } rpa_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [POFF_W-1:0]     page_offset;
    logic [COUNT_BITS-1:0] ref_count;
    logic                  page_released;
  } rpa_res_t;

  // Command bundle from the sequencer to the count memory
  typedef struct packed {
    logic                  we;
    logic [PAGE_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [PAGE_W-1:0]     raddr;
  } rpa_cnt_cmd_t;

  // Command bundle from the sequencer to the free stack memory
  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    logic [PAGE_W-1:0] wdata;
    logic [PAGE_W-1:0] raddr;
  } rpa_stk_cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } rpa_state_e;

endpackage

/* hw/rtl/rpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module rpa_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rpa_core.sv */
// Request sequencer: address check, memory read-modify-write and result register.
`timescale 1ns / 1ps
module rpa_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  rpa_pkg::rpa_req_t                 req_i,
  input  logic [rpa_pkg::CFG_W-1:0]         first_page_i,
  output logic                              busy_o,
  output logic                              res_valid_o,
  output rpa_pkg::rpa_res_t                 res_o,
  output rpa_pkg::rpa_cnt_cmd_t             cnt_cmd_o,
  input  logic [rpa_pkg::COUNT_BITS-1:0]    cnt_rdata_i,
  output rpa_pkg::rpa_stk_cmd_t             stk_cmd_o,
  input  logic [rpa_pkg::PAGE_W-1:0]        stk_rdata_i
);
  import rpa_pkg::*;

  rpa_state_e            state_q, state_d;
  logic [PAGE_W-1:0]     clr_q, clr_d;
  logic [DEPTH_W-1:0]    depth_q, depth_d;
  logic [PAGE_W-1:0]     fresh_q, fresh_d;
  logic                  exh_q, exh_d;
  logic                  res_vld_q, res_vld_d;
  rpa_res_t              res_q, res_d;
  logic [REQ_W-1:0]      req_q;
  logic [PAGE_W-1:0]     page_q;
  logic                  bad_q;

  logic                  accept;
  logic [IDX_W-1:0]      idx;
  logic                  bad_addr;
  logic [COUNT_BITS-1:0] cnt_m1;
  logic [PAGE_W-1:0]     alloc_pg;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // Page index and range check of the incoming offset
  assign idx      = req_i.address_offset[OFF_W-1:PAGE_SHIFT];
  assign bad_addr = (|req_i.address_offset[PAGE_SHIFT-1:0]) ||
                    ({1'b0, idx} >= (IDX_W+1)'(NUM_PAGES)) ||
                    (idx < IDX_W'(first_page_i));

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i.req_type;
      page_q <= idx[PAGE_W-1:0];
      bad_q  <= bad_addr;
    end
  end

  assign cnt_m1 = cnt_rdata_i - COUNT_BITS'(1);

  // Sequencer and read-modify-write
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    depth_d   = depth_q;
    fresh_d   = fresh_q;
    exh_d     = exh_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    alloc_pg  = fresh_q;

    cnt_cmd_o.we    = 1'b0;
    cnt_cmd_o.waddr = page_q;
    cnt_cmd_o.wdata = '0;
    cnt_cmd_o.raddr = idx[PAGE_W-1:0];
    stk_cmd_o.we    = 1'b0;
    stk_cmd_o.waddr = depth_q[PAGE_W-1:0];
    stk_cmd_o.wdata = page_q;
    stk_cmd_o.raddr = PAGE_W'(depth_q - DEPTH_W'(1));

    case (state_q)
      // Zero the count memory, one entry a cycle
      S_CLEAR: begin
        cnt_cmd_o.we    = 1'b1;
        cnt_cmd_o.waddr = clr_q;
        clr_d           = clr_q + PAGE_W'(1);
        if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Reads for the accepted request go out this cycle
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      // Memory data is back: decide, write back, register result
      S_EXEC: begin
        state_d   = S_IDLE;
        res_vld_d = 1'b1;
        res_d     = '0;
        if (req_q == REQ_ALLOC) begin
          if (depth_q != '0) begin
            alloc_pg = stk_rdata_i;
            depth_d  = depth_q - DEPTH_W'(1);
          end else if (exh_q || (fresh_q < first_page_i)) begin
            exh_d        = 1'b1;
            res_d.status = ST_NO_MEM;
          end else if (fresh_q == '0) begin
            exh_d = 1'b1;
          end else begin
            fresh_d = fresh_q - PAGE_W'(1);
          end
          if (res_d.status == ST_OK) begin
            cnt_cmd_o.we      = 1'b1;
            cnt_cmd_o.waddr   = alloc_pg;
            cnt_cmd_o.wdata   = COUNT_BITS'(1);
            res_d.page_offset = POFF_W'(alloc_pg) << PAGE_SHIFT;
            res_d.ref_count   = COUNT_BITS'(1);
          end
        end else if (bad_q) begin
          res_d.status = ST_BAD_ADDR;
        end else if (req_q == REQ_FREE) begin
          if (cnt_rdata_i == '0) begin
            res_d.status = ST_FREE_ZERO;
          end else begin
            cnt_cmd_o.we    = 1'b1;
            cnt_cmd_o.wdata = cnt_m1;
            if (cnt_m1 == '0) begin
              // Last reference gone: push on the free stack unless full
              res_d.page_released = 1'b1;
              if (depth_q < DEPTH_W'(NUM_PAGES)) begin
                stk_cmd_o.we = 1'b1;
                depth_d      = depth_q + DEPTH_W'(1);
              end
            end else begin
              res_d.ref_count = cnt_m1;
            end
          end
        end else if (req_q == REQ_ADD) begin
          if (cnt_rdata_i == COUNT_MAX) begin
            res_d.status    = ST_OVERFLOW;
            res_d.ref_count = cnt_rdata_i;
          end else begin
            cnt_cmd_o.we    = 1'b1;
            cnt_cmd_o.wdata = cnt_rdata_i + COUNT_BITS'(1);
            res_d.ref_count = cnt_rdata_i + COUNT_BITS'(1);
          end
        end else begin
          res_d.ref_count = cnt_rdata_i;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      depth_q   <= '0;
      fresh_q   <= PAGE_W'(NUM_PAGES - 1);
      exh_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      depth_q   <= depth_d;
      fresh_q   <= fresh_d;
      exh_q     <= exh_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

/* hw/rtl/refcounted_page_allocator_unit.sv */
// Top level of the reference-counted page allocator.
//
//   channel   direction  signals                          transfer when
//   request   in         start, busy, req_i               start && !busy
//   result    out        res_valid_o, res_o               res_valid_o
//   config    in         cfg_we_i, cfg_wdata_i            cfg_we_i
//
// For each request the count and free stack memories are read in the accept
// cycle and written back in the next, which also loads the result register.
// The result shows for one cycle, in which a new request is taken. After
// reset the count memory is zeroed, one entry a cycle, while busy stays high.
// Configuration is taken at any time. Results cannot stall.
`timescale 1ns / 1ps
module refcounted_page_allocator_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  rpa_pkg::rpa_req_t         req_i,
  output logic                      res_valid_o,
  output rpa_pkg::rpa_res_t         res_o,
  input  logic                      cfg_we_i,
  input  logic [rpa_pkg::CFG_W-1:0] cfg_wdata_i
);
  import rpa_pkg::*;

  logic [CFG_W-1:0]      first_page_q;
  rpa_cnt_cmd_t          cnt_cmd;
  rpa_stk_cmd_t          stk_cmd;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [PAGE_W-1:0]     stk_rdata;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= '0;
    end else if (cfg_we_i) begin
      first_page_q <= cfg_wdata_i;
    end
  end

  rpa_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .req_i        (req_i),
    .first_page_i (first_page_q),
    .busy_o       (busy),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o),
    .cnt_cmd_o    (cnt_cmd),
    .cnt_rdata_i  (cnt_rdata),
    .stk_cmd_o    (stk_cmd),
    .stk_rdata_i  (stk_rdata)
  );

  // Reference counts
  rpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (COUNT_BITS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_cmd.we),
    .waddr_i (cnt_cmd.waddr),
    .wdata_i (cnt_cmd.wdata),
    .raddr_i (cnt_cmd.raddr),
    .rdata_o (cnt_rdata)
  );

  // Free page stack
  rpa_ram #(
    .DEPTH (NUM_PAGES),
    .WIDTH (PAGE_W)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_cmd.we),
    .waddr_i (stk_cmd.waddr),
    .wdata_i (stk_cmd.wdata),
    .raddr_i (stk_cmd.raddr),
    .rdata_o (stk_rdata)
  );

`ifndef ASSERT_OFF
  // An accepted request yields its result once the execute state has loaded the result register
  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 res_valid_o)
    else $error("result missing two cycles after accept");

  // Busy while the request executes
  a_busy_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !res_valid_o))
    else $error("not busy in execute cycle");

  // Results never come back to back
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("results in consecutive cycles");

  // Failed requests carry no page and no release
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |->
      ((res_o.page_offset == '0) && !res_o.page_released))
    else $error("error result with page or release set");

  // A released page has no references left
  a_rel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.page_released) |-> (res_o.ref_count == '0))
    else $error("release with nonzero count");
`endif

endmodule
